// ===== sv/prx_pkg.sv =====
`timescale 1ns / 1ps

package prx_pkg;

	// digit base: every received byte is decoded as (byte - '0')
	localparam logic [7:0] DIGIT_BASE = 8'd48;

	// configuration register indexes
	localparam logic CFG_EXPECTED_COMMAND = 1'b0;
	localparam logic CFG_MAX_LENGTH       = 1'b1;

	// operation codes of an input request
	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// receiver phases, codes as seen on the result
	typedef enum logic [2:0] {
		PH_COMMAND  = 3'd0,
		PH_LENGTH   = 3'd1,
		PH_DATA     = 3'd2,
		PH_CHECKSUM = 3'd3,
		PH_FINISHED = 3'd4,
		PH_ERROR    = 3'd5
	} prx_phase_t;

	typedef struct packed {
		logic       operation;
		logic [7:0] rx_byte;
	} prx_in_t;

	typedef struct packed {
		logic        ok;
		logic [2:0]  phase;
		logic        write_enable;
		logic [15:0] write_index;
		logic [7:0]  write_byte;
		logic        sum_valid;
		logic [63:0] local_sum;
		logic        packet_done;
	} prx_out_t;

	typedef struct packed {
		logic [7:0]  expected_command;
		logic [15:0] max_length;
	} prx_cfg_t;

endpackage

// ===== sv/prx_core.sv =====
`timescale 1ns / 1ps

module prx_core import prx_pkg::*; #(
	parameter int CHECKSUM_BYTES = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  prx_in_t  item,
	input  prx_cfg_t cfg,
	output prx_out_t result
);

	prx_phase_t  phase_q, phase_d;
	logic [15:0] count_q, count_d;
	logic [15:0] length_q, length_d;
	logic [63:0] run_sum_q, run_sum_d;
	logic [63:0] rcv_sum_q, rcv_sum_d;

	logic [7:0]  digit;
	logic [8:0]  data_diff;
	logic [63:0] sum_next;
	logic [63:0] rcv_next;
	logic [15:0] length_full;
	logic [16:0] count_inc;
	logic        restart;
	logic        cmd_match;
	logic        len_ok;
	logic        data_last;
	logic        cks_last;
	logic        cks_match;

	// decode of the current byte
	assign restart     = (item.operation == OP_RESTART);
	assign digit       = item.rx_byte - DIGIT_BASE;
	assign data_diff   = {1'b0, item.rx_byte} - {1'b0, DIGIT_BASE};
	assign sum_next    = run_sum_q + {{55{data_diff[8]}}, data_diff};
	assign rcv_next    = {rcv_sum_q[55:0], digit};
	assign length_full = {length_q[7:0], digit};
	assign count_inc   = {1'b0, count_q} + 17'd1;
	assign cmd_match   = (digit == cfg.expected_command);
	assign len_ok      = (length_full <= cfg.max_length);
	assign data_last   = (length_q == 16'd0) || (count_inc >= {1'b0, length_q});
	assign cks_last    = (count_inc >= 17'(CHECKSUM_BYTES));
	assign cks_match   = (rcv_next == run_sum_q);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (restart) begin
			phase_d = PH_COMMAND;
		end else begin
			unique case (phase_q)
				PH_COMMAND:  phase_d = cmd_match ? PH_LENGTH : PH_ERROR;
				PH_LENGTH: begin
					if (count_q != 16'd0) begin
						phase_d = len_ok ? PH_DATA : PH_ERROR;
					end
				end
				PH_DATA:     phase_d = data_last ? PH_CHECKSUM : PH_DATA;
				PH_CHECKSUM: begin
					if (cks_last) begin
						phase_d = cks_match ? PH_FINISHED : PH_ERROR;
					end
				end
				PH_FINISHED: phase_d = PH_FINISHED;
				default:     phase_d = PH_ERROR;
			endcase
		end
	end

	// counters and sums
	always_comb begin
		count_d   = count_q;
		length_d  = length_q;
		run_sum_d = run_sum_q;
		rcv_sum_d = rcv_sum_q;
		if (restart) begin
			count_d   = '0;
			length_d  = '0;
			run_sum_d = '0;
			rcv_sum_d = '0;
		end else begin
			unique case (phase_q)
				PH_COMMAND: begin
					if (cmd_match) begin
						count_d = '0;
					end
				end
				PH_LENGTH: begin
					if (count_q == 16'd0) begin
						length_d = {8'd0, digit};
						count_d  = 16'd1;
					end else begin
						length_d = length_full;
						count_d  = '0;
					end
				end
				PH_DATA: begin
					run_sum_d = sum_next;
					if (data_last) begin
						count_d   = '0;
						rcv_sum_d = '0;
					end else begin
						count_d = count_inc[15:0];
					end
				end
				PH_CHECKSUM: begin
					rcv_sum_d = rcv_next;
					count_d   = cks_last ? 16'd0 : count_inc[15:0];
				end
				default: begin
					count_d = count_q;
				end
			endcase
		end
	end

	// result fields
	always_comb begin
		result              = '0;
		result.phase        = phase_d;
		if (restart) begin
			result.ok = 1'b1;
		end else begin
			unique case (phase_q)
				PH_COMMAND:  result.ok = cmd_match;
				PH_LENGTH:   result.ok = (count_q == 16'd0) || len_ok;
				PH_DATA: begin
					result.ok           = 1'b1;
					result.write_enable = 1'b1;
					result.write_index  = count_q;
					result.write_byte   = item.rx_byte;
					result.sum_valid    = data_last;
					result.local_sum    = data_last ? sum_next : 64'd0;
				end
				PH_CHECKSUM: begin
					result.ok          = !cks_last || cks_match;
					result.packet_done = cks_last && cks_match;
				end
				PH_FINISHED: result.ok = 1'b1;
				default:     result.ok = 1'b0;
			endcase
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_COMMAND;
			count_q   <= '0;
			length_q  <= '0;
			run_sum_q <= '0;
			rcv_sum_q <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			count_q   <= count_d;
			length_q  <= length_d;
			run_sum_q <= run_sum_d;
			rcv_sum_q <= rcv_sum_d;
		end
	end

`ifndef SYNTHESIS
	// a completed packet leaves the block in the finished phase
	a_done_finished: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.packet_done |=> phase_q == PH_FINISHED)
		else $error("packet done without finished phase");

	// data is only written out from the data phase
	a_write_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.write_enable |-> phase_q == PH_DATA && !restart)
		else $error("write outside data phase");

	// the local sum is shown once, then the checksum count starts from zero
	a_sum_to_cks: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.sum_valid |=> phase_q == PH_CHECKSUM && count_q == 16'd0)
		else $error("sum shown without entering checksum phase");

	// checksum byte count stays within the checksum length
	a_cks_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CHECKSUM |-> {1'b0, count_q} < 17'(CHECKSUM_BYTES))
		else $error("checksum byte count overrun");
`endif

endmodule

// ===== sv/packet_receiver_with_sum_check_unit.sv =====
`timescale 1ns / 1ps

// packet receiver with sum check
// input channel: in_valid / in_stall carry one request per byte: a received
//   byte, or a restart that clears the receiver and waits for a command
// output channel: out_valid / out_stall, exactly one result per request,
//   in order: ok flag, phase after the byte, data write strobe with index and
//   byte, local sum on the last data byte, and packet done on a good checksum
// configuration: cfg_valid / cfg_ready write expected_command (index 0) and
//   max_length (index 1); cfg_ready is always high, write only when idle
// order: a taken request first waits in the input register, and its result then
//   lands in the result register
// throughput: one request per cycle unless a held result stalls it; the whole
//   state update of a byte is one pass of logic from input to result register
// stall: while the result register is held, the input register keeps its
//   request and in_stall rises; a request is still taken while a finished
//   result waits, as long as the input register is moving on
// reset: both registers empty, receiver in the command phase with counts and
//   sums cleared, expected_command 0 and max_length 65535
module packet_receiver_with_sum_check_unit import prx_pkg::*; #(
	parameter int CHECKSUM_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  prx_in_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output prx_out_t    out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	logic     valid_s1;
	prx_in_t  item_s1;
	logic     out_valid_q;
	prx_out_t out_q;
	prx_cfg_t cfg_q;
	prx_out_t result;
	logic     advance;

	// pipeline control
	assign advance   = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_command <= '0;
			cfg_q.max_length       <= 16'hFFFF;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_EXPECTED_COMMAND: cfg_q.expected_command <= cfg_data[7:0];
				CFG_MAX_LENGTH:       cfg_q.max_length       <= cfg_data;
				default:              cfg_q                  <= cfg_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// receiver state and step logic
	prx_core #(
		.CHECKSUM_BYTES(CHECKSUM_BYTES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

`ifndef SYNTHESIS
	// the input side only waits on a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q && out_stall && valid_s1)
		else $error("input stalled without a held result");
`endif

endmodule

// ===== dv/packet_receiver_with_sum_check_unit_test.sv =====
`timescale 1ns / 1ps

module packet_receiver_with_sum_check_unit_test;
	import prx_pkg::*;

	localparam int CHECKSUM_BYTES = 8;
	localparam int CYCLE_LIMIT    = 400000;

	typedef enum {FLAW_NONE, FLAW_COMMAND, FLAW_CHECKSUM, FLAW_TRUNCATE} flaw_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	prx_in_t     in_data   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	prx_out_t    out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_EXPECTED_COMMAND;
	logic [15:0] cfg_data  = '0;

	// requests still to be driven, results still to arrive
	prx_in_t  byte_requests[$];
	prx_out_t predicted_status[$];

	logic in_taken = 1'b0;
	int   mismatch_count = 0;
	int   cycle_count = 0;
	int   queued_total = 0;
	int   sender_idle_pct = 0;
	int   receiver_stall_pct = 0;

	// settings the stimulus is shaped for
	logic [7:0] gen_command = 8'd0;
	int         gen_max_length = 65535;

	// receiver state as predicted
	logic [7:0]  cmd_setting = 8'd0;
	logic [15:0] max_len_setting = 16'hFFFF;
	prx_phase_t  rx_phase = PH_COMMAND;
	logic [15:0] rx_count = '0;
	logic [15:0] rx_length = '0;
	logic [63:0] rx_sum = '0;
	logic [63:0] rx_checksum = '0;

	packet_receiver_with_sum_check_unit #(
		.CHECKSUM_BYTES(CHECKSUM_BYTES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// one received byte or restart through the predicted receiver
	task automatic decode_byte(input prx_in_t req, output prx_out_t res);
		logic [7:0] digit;
		digit = req.rx_byte - DIGIT_BASE;
		res = '0;
		if (req.operation == OP_RESTART) begin
			rx_phase    = PH_COMMAND;
			rx_count    = '0;
			rx_length   = '0;
			rx_sum      = '0;
			rx_checksum = '0;
			res.ok      = 1'b1;
		end else begin
			case (rx_phase)
			PH_COMMAND: begin
				if (digit == cmd_setting) begin
					rx_phase = PH_LENGTH;
					rx_count = '0;
					res.ok   = 1'b1;
				end else begin
					rx_phase = PH_ERROR;
				end
			end
			PH_LENGTH: begin
				if (rx_count == 16'd0) begin
					rx_length = {8'd0, digit};
					rx_count  = 16'd1;
					res.ok    = 1'b1;
				end else begin
					rx_length = {rx_length[7:0], digit};
					rx_count  = '0;
					if (rx_length <= max_len_setting) begin
						rx_phase = PH_DATA;
						res.ok   = 1'b1;
					end else begin
						rx_phase = PH_ERROR;
					end
				end
			end
			PH_DATA: begin
				res.write_enable = 1'b1;
				res.write_index  = rx_count;
				res.write_byte   = req.rx_byte;
				rx_sum = rx_sum + 64'(req.rx_byte) - 64'(DIGIT_BASE);
				res.ok = 1'b1;
				// a zero length still carries one data byte
				if (rx_length == 16'd0 || 17'(rx_count) + 17'd1 >= 17'(rx_length)) begin
					rx_count      = '0;
					rx_phase      = PH_CHECKSUM;
					rx_checksum   = '0;
					res.sum_valid = 1'b1;
					res.local_sum = rx_sum;
				end else begin
					rx_count = rx_count + 16'd1;
				end
			end
			PH_CHECKSUM: begin
				rx_checksum = {rx_checksum[55:0], digit};
				if (int'(rx_count) + 1 < CHECKSUM_BYTES) begin
					rx_count = rx_count + 16'd1;
					res.ok   = 1'b1;
				end else begin
					rx_count = '0;
					if (rx_checksum == rx_sum) begin
						rx_phase        = PH_FINISHED;
						res.packet_done = 1'b1;
						res.ok          = 1'b1;
					end else begin
						rx_phase = PH_ERROR;
					end
				end
			end
			PH_FINISHED: begin
				res.ok = 1'b1;
			end
			default: begin
				rx_phase = PH_ERROR;
			end
			endcase
		end
		res.phase = rx_phase;
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// register writes, request prediction and result checking
	always @(posedge clk) begin
		prx_out_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_EXPECTED_COMMAND: cmd_setting = cfg_data[7:0];
				CFG_MAX_LENGTH:       max_len_setting = cfg_data;
				default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				decode_byte(in_data, want);
				predicted_status.push_back(want);
			end
			if (out_valid && !out_stall) begin
				if (predicted_status.size() == 0) begin
					report_mismatch("result with no request waiting, phase",
						64'(out_data.phase), '0);
				end else begin
					want = predicted_status.pop_front();
					if (out_data.ok !== want.ok)
						report_mismatch("ok", 64'(out_data.ok), 64'(want.ok));
					if (out_data.phase !== want.phase)
						report_mismatch("phase", 64'(out_data.phase), 64'(want.phase));
					if (out_data.write_enable !== want.write_enable)
						report_mismatch("write_enable", 64'(out_data.write_enable),
							64'(want.write_enable));
					if (out_data.write_index !== want.write_index)
						report_mismatch("write_index", 64'(out_data.write_index),
							64'(want.write_index));
					if (out_data.write_byte !== want.write_byte)
						report_mismatch("write_byte", 64'(out_data.write_byte),
							64'(want.write_byte));
					if (out_data.sum_valid !== want.sum_valid)
						report_mismatch("sum_valid", 64'(out_data.sum_valid),
							64'(want.sum_valid));
					if (out_data.local_sum !== want.local_sum)
						report_mismatch("local_sum", out_data.local_sum, want.local_sum);
					if (out_data.packet_done !== want.packet_done)
						report_mismatch("packet_done", 64'(out_data.packet_done),
							64'(want.packet_done));
				end
			end
		end
		in_taken <= arst_n && in_valid && !in_stall;
	end

	// request driver: a held request stays put until taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (byte_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
				in_data  <= byte_requests.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result back-pressure
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
	end

	task automatic push_item(input logic operation, input logic [7:0] rx_byte);
		prx_in_t req;
		req.operation = operation;
		req.rx_byte   = rx_byte;
		byte_requests.push_back(req);
		queued_total++;
	endtask

	// restart, command, length, data and checksum, with an optional flaw
	task automatic push_packet(input logic [7:0] command, input int length,
			input flaw_t flaw, input int fill);
		logic [63:0] sum;
		logic [7:0]  data;
		int          n;
		int          bad_pos;
		sum     = '0;
		bad_pos = -1;
		n = (length == 0) ? 1 : length;
		if (flaw == FLAW_TRUNCATE)
			n = $urandom_range(0, (n < 4) ? n - 1 : 3);
		push_item(OP_RESTART, 8'($urandom));
		if (flaw == FLAW_COMMAND) begin
			push_item(OP_BYTE, command + DIGIT_BASE + 8'($urandom_range(1, 255)));
			push_item(OP_BYTE, 8'($urandom));
			return;
		end
		push_item(OP_BYTE, command + DIGIT_BASE);
		push_item(OP_BYTE, 8'(length >> 8) + DIGIT_BASE);
		push_item(OP_BYTE, 8'(length) + DIGIT_BASE);
		// too long: the receiver is already in error
		if (length > gen_max_length)
			return;
		for (int i = 0; i < n; i++) begin
			data = (fill > 255) ? 8'($urandom) : 8'(fill);
			sum  = sum + 64'(data) - 64'(DIGIT_BASE);
			push_item(OP_BYTE, data);
		end
		if (flaw == FLAW_TRUNCATE)
			return;
		if (flaw == FLAW_CHECKSUM)
			bad_pos = $urandom_range(0, CHECKSUM_BYTES - 1);
		// checksum digits, high byte first
		for (int i = 0; i < CHECKSUM_BYTES; i++) begin
			data = sum[63 - 8 * i -: 8] + DIGIT_BASE;
			if (i == bad_pos)
				data = data ^ 8'($urandom_range(1, 255));
			push_item(OP_BYTE, data);
		end
	endtask

	// mostly well-formed packets, some noise, stray restarts
	task automatic run_random(input int n_items);
		int    start;
		int    r;
		int    length;
		flaw_t flaw;
		start = queued_total;
		while (queued_total - start < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				flaw = FLAW_NONE;
				r = $urandom_range(0, 9);
				if (r < 7) begin
					length = $urandom_range(0, (gen_max_length < 12) ? gen_max_length : 12);
				end else if (r == 7 && gen_max_length <= 300) begin
					length = gen_max_length;
				end else if (r == 8 && gen_max_length < 65535) begin
					length = gen_max_length + 1;
				end else begin
					length = $urandom_range(0, 65535);
					flaw   = FLAW_TRUNCATE;
				end
				if (flaw == FLAW_NONE) begin
					case ($urandom_range(0, 9))
					0: flaw = FLAW_COMMAND;
					1: flaw = FLAW_CHECKSUM;
					2: flaw = FLAW_TRUNCATE;
					default: ;
					endcase
				end
				push_packet(gen_command, length, flaw, 256);
			end else if (r < 90) begin
				repeat ($urandom_range(1, 4)) push_item(OP_BYTE, 8'($urandom));
			end else begin
				push_item(1'($urandom), 8'($urandom));
			end
		end
	endtask

	// all requests taken and every predicted result seen
	task automatic wait_idle();
		while (byte_requests.size() != 0 || in_valid || predicted_status.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_register(input logic index, input logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input logic [7:0] command, input logic [15:0] max_length,
			input int idle_pct, input int stall_pct);
		write_register(CFG_EXPECTED_COMMAND, {8'd0, command});
		write_register(CFG_MAX_LENGTH, max_length);
		gen_command        = command;
		gen_max_length     = max_length;
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
	endtask

	// watchdog
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: zero length with a wrapping sum, byte after finish,
		// bad command, largest length cut short
		push_packet(8'd0, 0, FLAW_NONE, 0);
		push_item(OP_BYTE, 8'hFF);
		push_packet(8'd0, 1, FLAW_COMMAND, 0);
		push_packet(8'd0, 65535, FLAW_TRUNCATE, 255);
		wait_idle();

		for (int p = 0; p < 5; p++) begin
			case (p)
			0: begin
				configure(8'hFF, 16'd0, 0, 0);
				// one byte too long, then the only length allowed
				push_packet(8'hFF, 1, FLAW_NONE, 256);
				push_packet(8'hFF, 0, FLAW_NONE, 256);
			end
			1: configure(8'd208, 16'hFFFF, 63, 0);
			2: configure(8'($urandom), 16'($urandom_range(1, 20)), 0, 63);
			3: configure(8'd0, 16'd300, 37, 37);
			default: configure(8'($urandom), 16'($urandom), 63, 0);
			endcase
			run_random(100);
			// sender holds off until the receiver has drained
			wait_idle();
			run_random(100);
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
